@@ design/lfms_pkg.sv @@
// ----------------------------------------------------------------------------
// lfms_pkg
// Types, mode codes, register indexes and reset values shared by the line
// follower mode sequencer.
// ----------------------------------------------------------------------------
package lfms_pkg;

	typedef enum logic [2:0] {
		MODE_IDLE     = 3'd0,
		MODE_STRAIGHT = 3'd1,
		MODE_TURNING  = 3'd2,
		MODE_SLOW     = 3'd3,
		MODE_STOPPING = 3'd4,
		MODE_STOPPED  = 3'd5
	} mode_t;

	localparam int unsigned CfgIdxW  = 3;
	localparam int unsigned CfgDataW = 8;

	localparam logic [CfgIdxW-1:0] REG_TOP_SPEED  = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_RAMP_STEP  = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_BASE_SPEED = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_SLOW_SPEED = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_LAP_LIMIT  = 3'd4;

	localparam logic [7:0] RST_TOP_SPEED  = 8'd120;
	localparam logic [7:0] RST_RAMP_STEP  = 8'd5;
	localparam logic [7:0] RST_BASE_SPEED = 8'd50;
	localparam logic [7:0] RST_SLOW_SPEED = 8'd25;
	localparam logic [3:0] RST_LAP_LIMIT  = 4'd3;
	localparam logic [7:0] RST_SPEED      = 8'd50;

	typedef struct packed {
		logic start_pressed;
		logic in_slow_zone;
		logic stop_line_seen;
		logic past_start_marker;
		logic in_curve;
	} sensor_t;

	typedef struct packed {
		logic [2:0] mode;
		logic [7:0] speed;
		logic       red_led;
		logic       green_led;
		logic       slow_signal;
		logic       motors_off;
	} drive_t;

	typedef struct packed {
		logic [7:0] top_speed;
		logic [7:0] ramp_step;
		logic [7:0] base_speed;
		logic [7:0] slow_speed;
		logic [3:0] lap_limit;
	} cfg_t;

	typedef struct packed {
		mode_t      mode;
		logic [7:0] speed;
		logic [3:0] laps_done;
		logic       red_on;
		logic       green_on;
		logic       slow_sig_on;
	} state_t;

endpackage

@@ design/lfms_sensor_if.sv @@
// ----------------------------------------------------------------------------
// lfms_sensor_if
// Request channel carrying one tick of button and track flags.
// ----------------------------------------------------------------------------
interface lfms_sensor_if;
	import lfms_pkg::*;

	logic    valid;
	logic    ready;
	sensor_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);

endinterface

@@ design/lfms_drive_if.sv @@
// ----------------------------------------------------------------------------
// lfms_drive_if
// Result channel carrying mode, speed, LED and motor states.
// ----------------------------------------------------------------------------
interface lfms_drive_if;
	import lfms_pkg::*;

	logic   valid;
	logic   ready;
	drive_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);

endinterface

@@ design/line_follower_mode_sequencer.sv @@
// ----------------------------------------------------------------------------
// line_follower_mode_sequencer
// Drive mode sequencer for a line follower: one tick of flags in, one
// result of mode, speed, LEDs, slow signal and motors-off out.
//
//   channel  | dir | handshake     | payload
//   ---------+-----+---------------+------------------------------------------
//   sensor   | in  | valid/ready   | start, slow zone, stop line, marker, curve
//   drive    | out | valid/ready   | mode, speed, red, green, slow, motors_off
//   cfg      | in  | cfg_we only   | cfg_idx selects register, cfg_data value
//
// From request to result: input register, then the mode step
// into the result register, which also updates the machine state.
// One request per cycle sustained while drive is ready; the state loop holds one register.
// Reset returns config, valid flags and state to power-on values; data registers are not reset.
// A stalled result holds; the input register keeps taking requests while
// the result register is free or being drained.
// ----------------------------------------------------------------------------
module line_follower_mode_sequencer (
	input  logic                                clk,
	input  logic                                arst_n,
	lfms_sensor_if.sink                         sensor,
	lfms_drive_if.source                        drive,
	input  logic                                cfg_we,
	input  logic [lfms_pkg::CfgIdxW-1:0]        cfg_idx,
	input  logic [lfms_pkg::CfgDataW-1:0]       cfg_data
);
	import lfms_pkg::*;

	cfg_t    cfg_q;
	state_t  state_q;
	state_t  state_nxt;
	sensor_t sns_s1;
	logic    vld_s1;
	drive_t  res_s2;
	drive_t  res_nxt;
	logic    vld_s2;
	logic    advance;

	assign advance      = vld_s1 && (!vld_s2 || drive.ready);
	assign sensor.ready = !vld_s1 || advance;
	assign drive.valid  = vld_s2;
	assign drive.data   = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.top_speed  <= RST_TOP_SPEED;
			cfg_q.ramp_step  <= RST_RAMP_STEP;
			cfg_q.base_speed <= RST_BASE_SPEED;
			cfg_q.slow_speed <= RST_SLOW_SPEED;
			cfg_q.lap_limit  <= RST_LAP_LIMIT;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_TOP_SPEED:  cfg_q.top_speed  <= cfg_data;
				REG_RAMP_STEP:  cfg_q.ramp_step  <= cfg_data;
				REG_BASE_SPEED: cfg_q.base_speed <= cfg_data;
				REG_SLOW_SPEED: cfg_q.slow_speed <= cfg_data;
				REG_LAP_LIMIT:  cfg_q.lap_limit  <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	lfms_step u_step (
		.cfg (cfg_q),
		.cur (state_q),
		.sns (sns_s1),
		.nxt (state_nxt),
		.res (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1              <= 1'b0;
			vld_s2              <= 1'b0;
			state_q.mode        <= MODE_IDLE;
			state_q.speed       <= RST_SPEED;
			state_q.laps_done   <= 4'd0;
			state_q.red_on      <= 1'b0;
			state_q.green_on    <= 1'b0;
			state_q.slow_sig_on <= 1'b0;
		end else begin
			if (sensor.ready) begin
				vld_s1 <= sensor.valid;
			end
			if (advance) begin
				vld_s2  <= 1'b1;
				state_q <= state_nxt;
			end else if (drive.ready) begin
				vld_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sensor.valid && sensor.ready) begin
			sns_s1 <= sensor.data;
		end
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	a_advance_fills: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> vld_s2)
		else $error("result register not filled after step");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(sensor.valid && sensor.ready && vld_s1) |-> advance)
		else $error("input register overwritten before step");

	a_motors_off: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && state_q.mode == MODE_STOPPED) |=> drive.data.motors_off)
		else $error("stopped step did not flag motors off");

	a_stopped_speed: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && res_s2.mode == MODE_STOPPED) |-> (res_s2.speed == 8'd0))
		else $error("stopped mode with nonzero speed");

endmodule

@@ design/lfms_step.sv @@
// ----------------------------------------------------------------------------
// lfms_step
// One step of the drive mode machine: next state and result from the current
// state, the registers and one tick of flags.
// ----------------------------------------------------------------------------
module lfms_step (
	input  lfms_pkg::cfg_t    cfg,
	input  lfms_pkg::state_t  cur,
	input  lfms_pkg::sensor_t sns,
	output lfms_pkg::state_t  nxt,
	output lfms_pkg::drive_t  res
);
	import lfms_pkg::*;

	logic [8:0] ramp_sum;
	logic [3:0] laps_inc;
	logic       motors_off;

	assign ramp_sum = {1'b0, cur.speed} + {1'b0, cfg.ramp_step};
	assign laps_inc = cur.laps_done + 4'd1;

	always_comb begin
		nxt        = cur;
		motors_off = 1'b0;
		case (cur.mode)
			MODE_STRAIGHT: begin
				nxt.green_on = 1'b1;
				if (ramp_sum > {1'b0, cfg.top_speed}) begin
					nxt.speed = cfg.top_speed;
				end else begin
					nxt.speed = ramp_sum[7:0];
				end
				if (sns.in_curve) begin
					nxt.green_on = 1'b0;
					nxt.mode     = MODE_TURNING;
				end else if (sns.stop_line_seen && !sns.past_start_marker) begin
					nxt.green_on = 1'b0;
					nxt.mode     = MODE_STOPPING;
				end else if (sns.in_slow_zone) begin
					nxt.green_on = 1'b0;
					nxt.mode     = MODE_SLOW;
				end
			end
			MODE_TURNING: begin
				nxt.speed = cfg.base_speed;
				if (!sns.in_curve) begin
					nxt.mode = MODE_STRAIGHT;
				end
			end
			MODE_SLOW: begin
				if (sns.in_slow_zone) begin
					nxt.slow_sig_on = 1'b1;
					nxt.green_on    = 1'b1;
					nxt.speed       = cfg.slow_speed;
				end else begin
					nxt.slow_sig_on = 1'b0;
					nxt.green_on    = 1'b0;
					nxt.speed       = cfg.base_speed;
					nxt.mode        = MODE_STRAIGHT;
				end
			end
			MODE_STOPPING: begin
				nxt.red_on = 1'b1;
				if (cur.speed < cfg.ramp_step) begin
					nxt.speed = 8'd0;
					nxt.mode  = MODE_STOPPED;
				end else begin
					nxt.speed = cur.speed - cfg.ramp_step;
				end
			end
			MODE_STOPPED: begin
				motors_off = 1'b1;
				if (laps_inc < cfg.lap_limit) begin
					nxt.laps_done = laps_inc;
					nxt.red_on    = 1'b0;
					nxt.speed     = cfg.base_speed;
					nxt.mode      = MODE_STRAIGHT;
				end else begin
					nxt.laps_done = 4'd0;
					nxt.mode      = MODE_IDLE;
				end
			end
			default: begin
				nxt.mode = MODE_IDLE;
				if (sns.start_pressed) begin
					nxt.red_on = 1'b0;
					nxt.speed  = cfg.base_speed;
					nxt.mode   = MODE_STRAIGHT;
				end else begin
					nxt.red_on = 1'b1;
				end
			end
		endcase
	end

	always_comb begin
		res.mode        = nxt.mode;
		res.speed       = nxt.speed;
		res.red_led     = nxt.red_on;
		res.green_led   = nxt.green_on;
		res.slow_signal = nxt.slow_sig_on;
		res.motors_off  = motors_off;
	end

endmodule
